[design/tfl_pkg.sv]
// Shared constants for the triangle-from-three-lines core.
// No dependencies.
`default_nettype none
package tfl_pkg;
  localparam int COEF_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int VTX_W          = 32;
  localparam int SIDE_W         = 32;
  localparam int AREA_W         = 48;
  localparam int OUT_W          = 6 * VTX_W + 3 * SIDE_W + AREA_W;
  localparam int DIV_STEPS      = 31;
  localparam int SQ1_N          = 33;
  localparam int SQ2_N          = 68;
endpackage
`default_nettype wire

[design/triangle_from_three_lines_core.sv]
// Triangle from three lines: pipelined core with Cramer division and Heron area.
// Depends on tfl_pkg.
//
// Takes one set of three lines per cycle while in_tready is high and returns one
// result item per set. The pipeline depth comes mostly from the
// 31-step quotient pipeline, the 33-step side square root and the 68-step
// area square root, each one bit per register stage. Throughput is one item
// per cycle whenever out_tready is high; a stall holds the whole pipeline.
`default_nettype none
module triangle_from_three_lines_core import tfl_pkg::*; #(
  parameter int COEF_WIDTH = COEF_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // first_a, first_b, first_c, second_a, second_b, second_c, third_a, third_b, third_c
  input  logic [((9*COEF_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // vertex_one_two_x, vertex_one_two_y, vertex_two_three_x, vertex_two_three_y,
  // vertex_three_one_x, vertex_three_one_y, side_first, side_second, side_third,
  // triangle_area
  output logic [OUT_W-1:0] out_tdata,
  // parallel_flag
  output logic [0:0] out_tuser
);

  localparam int CW = COEF_WIDTH;
  localparam int PW = 2 * CW;
  localparam int DW = PW + 1;
  localparam int RW = PW + FRAC_BITS + 32;
  localparam int QW = DIV_STEPS;
  localparam int N1 = SQ1_N;
  localparam int W1 = 2 * N1;
  localparam int N2 = SQ2_N;
  localparam int W2 = 2 * N2;
  localparam int CLW = 64;
  localparam int ST_DIV0 = 2;
  localparam int ST_VTX  = ST_DIV0 + QW + 1;
  localparam int ST_DX   = ST_VTX + 1;
  localparam int ST_SQ   = ST_DX + 1;
  localparam int ST_SUM  = ST_SQ + 1;
  localparam int ST_SIDE = ST_SUM + N1 + 1;
  localparam int ST_H1   = ST_SIDE + 1;
  localparam int ST_H2   = ST_H1 + 1;
  localparam int ST_H3   = ST_H2 + 1;
  localparam int ST_H4   = ST_H3 + 1;
  localparam int ST_OUT  = ST_H4 + N2 + 1;
  localparam int LAT     = ST_OUT + 1;

  logic en;
  logic [LAT-1:0] vld_r;
  logic par_r [1:ST_OUT];

  logic signed [CW-1:0] ca [3];
  logic signed [CW-1:0] cb [3];
  logic signed [CW-1:0] cc [3];
  logic signed [PW-1:0] prod_r [18];
  logic signed [DW-1:0] dif [9];
  logic par_c;
  logic [DW-1:0] dmag_r [3];
  logic [DW-1:0] nmag_r [6];
  logic nneg_r [6];

  logic [RW-1:0] rem_r [0:QW][6];
  logic [QW-1:0] quo_r [0:QW][6];
  logic [DW-1:0] den_r [0:QW][3];
  logic neg_r [0:QW][6];
  logic sat_r [0:QW][6];

  logic signed [VTX_W-1:0] vert_r [ST_VTX:ST_OUT][6];
  logic signed [VTX_W:0] ddx [3];
  logic signed [VTX_W:0] ddy [3];
  logic [VTX_W:0] dxm_r [3];
  logic [VTX_W:0] dym_r [3];
  logic [W1-1:0] sq_r [6];

  logic [W1-1:0] s1_rad_r [0:N1][3];
  logic [N1+3:0] s1_rem_r [0:N1][3];
  logic [N1-1:0] s1_root_r [0:N1][3];
  logic [N1+3:0] s1_rem2 [0:N1-1][3];
  logic [N1+4:0] s1_dif [0:N1-1][3];

  logic [SIDE_W-1:0] side_r [ST_SIDE:ST_OUT][3];
  logic [SIDE_W+1:0] hsum;
  logic signed [SIDE_W+2:0] hf [3];
  logic [SIDE_W+1:0] hf_r [4];
  logic hneg_r [ST_H1:ST_OUT-1];
  logic [2*SIDE_W+3:0] hm_r [2];
  logic [2*SIDE_W+3:0] hp_r [4];

  logic [W2-1:0] s2_rad_r [0:N2];
  logic [N2+3:0] s2_rem_r [0:N2];
  logic [N2-1:0] s2_root_r [0:N2];
  logic [N2+3:0] s2_rem2 [0:N2-1];
  logic [N2+4:0] s2_dif [0:N2-1];

  logic [CLW-1:0] area_cl;
  logic [CLW-1:0] area_sh;
  logic [AREA_W-1:0] area_r;

  assign en        = !vld_r[ST_OUT] || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_tvalid};
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ca[i] = in_tdata[(3*i)*CW +: CW];
      cb[i] = in_tdata[(3*i+1)*CW +: CW];
      cc[i] = in_tdata[(3*i+2)*CW +: CW];
    end
    for (int t = 0; t < 9; t++) begin
      dif[t] = DW'(prod_r[2*t]) - DW'(prod_r[2*t+1]);
    end
    par_c = (dif[0] == '0) || (dif[3] == '0) || (dif[6] == '0);
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ddx[i] = (VTX_W+1)'(vert_r[ST_VTX][(i == 2) ? 0 : 2*i+2])
             - (VTX_W+1)'(vert_r[ST_VTX][2*i]);
      ddy[i] = (VTX_W+1)'(vert_r[ST_VTX][(i == 2) ? 1 : 2*i+3])
             - (VTX_W+1)'(vert_r[ST_VTX][2*i+1]);
    end
    for (int k = 0; k < N1; k++) begin
      for (int i = 0; i < 3; i++) begin
        s1_rem2[k][i] = {s1_rem_r[k][i][N1+1:0], s1_rad_r[k][i][W1-1 -: 2]};
        s1_dif[k][i]  = {1'b0, s1_rem2[k][i]} - (N1+5)'({s1_root_r[k][i], 2'b01});
      end
    end
    hsum = (SIDE_W+2)'(side_r[ST_SIDE][0]) + (SIDE_W+2)'(side_r[ST_SIDE][1])
         + (SIDE_W+2)'(side_r[ST_SIDE][2]);
    for (int i = 0; i < 3; i++) begin
      hf[i] = (SIDE_W+3)'(side_r[ST_SIDE][0]) + (SIDE_W+3)'(side_r[ST_SIDE][1])
            + (SIDE_W+3)'(side_r[ST_SIDE][2])
            - ((SIDE_W+3)'(side_r[ST_SIDE][i]) << 1);
    end
    for (int k = 0; k < N2; k++) begin
      s2_rem2[k] = {s2_rem_r[k][N2+1:0], s2_rad_r[k][W2-1 -: 2]};
      s2_dif[k]  = {1'b0, s2_rem2[k]} - (N2+5)'({s2_root_r[k], 2'b01});
    end
    // clamp the root to 64 bits before scaling
    area_cl = (s2_root_r[N2][N2-1:CLW] != '0) ? {CLW{1'b1}} : s2_root_r[N2][CLW-1:0];
    area_sh = area_cl >> (FRAC_BITS + 2);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      par_r[1] <= par_c;
      for (int s = 2; s <= ST_OUT; s++) begin
        par_r[s] <= par_r[s-1];
      end
      // cross products
      for (int i = 0; i < 3; i++) begin
        prod_r[6*i]   <= PW'(ca[i]) * PW'(cb[(i == 2) ? 0 : i+1]);
        prod_r[6*i+1] <= PW'(ca[(i == 2) ? 0 : i+1]) * PW'(cb[i]);
        prod_r[6*i+2] <= PW'(cc[i]) * PW'(cb[(i == 2) ? 0 : i+1]);
        prod_r[6*i+3] <= PW'(cc[(i == 2) ? 0 : i+1]) * PW'(cb[i]);
        prod_r[6*i+4] <= PW'(ca[i]) * PW'(cc[(i == 2) ? 0 : i+1]);
        prod_r[6*i+5] <= PW'(ca[(i == 2) ? 0 : i+1]) * PW'(cc[i]);
      end
      // signs and magnitudes
      for (int i = 0; i < 3; i++) begin
        dmag_r[i] <= dif[3*i][DW-1] ? DW'(-dif[3*i]) : DW'(dif[3*i]);
        for (int t = 0; t < 2; t++) begin
          nmag_r[2*i+t] <= dif[3*i+1+t][DW-1] ? DW'(-dif[3*i+1+t]) : DW'(dif[3*i+1+t]);
          nneg_r[2*i+t] <= dif[3*i+1+t][DW-1] ^ dif[3*i][DW-1];
        end
      end
      // quotient setup and overflow test
      for (int m = 0; m < 6; m++) begin
        rem_r[0][m] <= RW'({nmag_r[m], {FRAC_BITS{1'b0}}});
        quo_r[0][m] <= '0;
        neg_r[0][m] <= nneg_r[m];
        sat_r[0][m] <= RW'({nmag_r[m], {FRAC_BITS{1'b0}}}) >= (RW'(dmag_r[m>>1]) << QW);
      end
      for (int i = 0; i < 3; i++) begin
        den_r[0][i] <= dmag_r[i];
      end
      // one quotient bit per stage
      for (int k = 0; k < QW; k++) begin
        for (int m = 0; m < 6; m++) begin
          if (rem_r[k][m] >= (RW'(den_r[k][m>>1]) << (QW-1-k))) begin
            rem_r[k+1][m] <= rem_r[k][m] - (RW'(den_r[k][m>>1]) << (QW-1-k));
            quo_r[k+1][m] <= quo_r[k][m] | (QW'(1) << (QW-1-k));
          end else begin
            rem_r[k+1][m] <= rem_r[k][m];
            quo_r[k+1][m] <= quo_r[k][m];
          end
          neg_r[k+1][m] <= neg_r[k][m];
          sat_r[k+1][m] <= sat_r[k][m];
        end
        for (int i = 0; i < 3; i++) begin
          den_r[k+1][i] <= den_r[k][i];
        end
      end
      // vertices, saturated; zero when the lines are parallel
      for (int m = 0; m < 6; m++) begin
        if (par_r[ST_VTX-1]) begin
          vert_r[ST_VTX][m] <= '0;
        end else if (sat_r[QW][m]) begin
          vert_r[ST_VTX][m] <= neg_r[QW][m] ? {1'b1, {(VTX_W-1){1'b0}}}
                                            : {1'b0, {(VTX_W-1){1'b1}}};
        end else begin
          vert_r[ST_VTX][m] <= neg_r[QW][m] ? -VTX_W'(quo_r[QW][m])
                                            : VTX_W'(quo_r[QW][m]);
        end
      end
      for (int s = ST_VTX + 1; s <= ST_OUT; s++) begin
        vert_r[s] <= vert_r[s-1];
      end
      // side lengths
      for (int i = 0; i < 3; i++) begin
        dxm_r[i] <= ddx[i][VTX_W] ? (VTX_W+1)'(-ddx[i]) : (VTX_W+1)'(ddx[i]);
        dym_r[i] <= ddy[i][VTX_W] ? (VTX_W+1)'(-ddy[i]) : (VTX_W+1)'(ddy[i]);
        sq_r[2*i]   <= W1'(dxm_r[i]) * W1'(dxm_r[i]);
        sq_r[2*i+1] <= W1'(dym_r[i]) * W1'(dym_r[i]);
        s1_rad_r[0][i]  <= sq_r[2*i] + sq_r[2*i+1];
        s1_rem_r[0][i]  <= '0;
        s1_root_r[0][i] <= '0;
      end
      for (int k = 0; k < N1; k++) begin
        for (int i = 0; i < 3; i++) begin
          s1_rad_r[k+1][i] <= s1_rad_r[k][i] << 2;
          if (!s1_dif[k][i][N1+4]) begin
            s1_rem_r[k+1][i]  <= s1_dif[k][i][N1+3:0];
            s1_root_r[k+1][i] <= {s1_root_r[k][i][N1-2:0], 1'b1};
          end else begin
            s1_rem_r[k+1][i]  <= s1_rem2[k][i];
            s1_root_r[k+1][i] <= {s1_root_r[k][i][N1-2:0], 1'b0};
          end
        end
      end
      for (int i = 0; i < 3; i++) begin
        side_r[ST_SIDE][i] <= s1_root_r[N1][i][N1-1] ? {SIDE_W{1'b1}}
                                                      : s1_root_r[N1][i][SIDE_W-1:0];
      end
      for (int s = ST_SIDE + 1; s <= ST_OUT; s++) begin
        side_r[s] <= side_r[s-1];
      end
      // Heron product
      hf_r[0] <= hsum;
      for (int i = 0; i < 3; i++) begin
        hf_r[i+1] <= hf[i][SIDE_W+1:0];
      end
      hneg_r[ST_H1] <= hf[0][SIDE_W+2] || hf[1][SIDE_W+2] || hf[2][SIDE_W+2];
      for (int s = ST_H1 + 1; s <= ST_OUT - 1; s++) begin
        hneg_r[s] <= hneg_r[s-1];
      end
      hm_r[0] <= (2*SIDE_W+4)'(hf_r[0]) * (2*SIDE_W+4)'(hf_r[1]);
      hm_r[1] <= (2*SIDE_W+4)'(hf_r[2]) * (2*SIDE_W+4)'(hf_r[3]);
      hp_r[0] <= (2*SIDE_W+4)'(hm_r[0][SIDE_W+1:0]) * (2*SIDE_W+4)'(hm_r[1][SIDE_W+1:0]);
      hp_r[1] <= (2*SIDE_W+4)'(hm_r[0][SIDE_W+1:0])
               * (2*SIDE_W+4)'(hm_r[1][2*SIDE_W+3:SIDE_W+2]);
      hp_r[2] <= (2*SIDE_W+4)'(hm_r[0][2*SIDE_W+3:SIDE_W+2])
               * (2*SIDE_W+4)'(hm_r[1][SIDE_W+1:0]);
      hp_r[3] <= (2*SIDE_W+4)'(hm_r[0][2*SIDE_W+3:SIDE_W+2])
               * (2*SIDE_W+4)'(hm_r[1][2*SIDE_W+3:SIDE_W+2]);
      s2_rad_r[0]  <= W2'(hp_r[0]) + ((W2'(hp_r[1]) + W2'(hp_r[2])) << (SIDE_W+2))
                    + (W2'(hp_r[3]) << (2*SIDE_W+4));
      s2_rem_r[0]  <= '0;
      s2_root_r[0] <= '0;
      for (int k = 0; k < N2; k++) begin
        s2_rad_r[k+1] <= s2_rad_r[k] << 2;
        if (!s2_dif[k][N2+4]) begin
          s2_rem_r[k+1]  <= s2_dif[k][N2+3:0];
          s2_root_r[k+1] <= {s2_root_r[k][N2-2:0], 1'b1};
        end else begin
          s2_rem_r[k+1]  <= s2_rem2[k];
          s2_root_r[k+1] <= {s2_root_r[k][N2-2:0], 1'b0};
        end
      end
      if (hneg_r[ST_OUT-1]) begin
        area_r <= '0;
      end else if (area_sh[CLW-1:AREA_W] != '0) begin
        area_r <= {AREA_W{1'b1}};
      end else begin
        area_r <= area_sh[AREA_W-1:0];
      end
    end
  end

  assign out_tvalid = vld_r[ST_OUT];
  assign out_tuser  = par_r[ST_OUT];
  assign out_tdata  = {area_r, side_r[ST_OUT][2], side_r[ST_OUT][1], side_r[ST_OUT][0],
                       vert_r[ST_OUT][5], vert_r[ST_OUT][4], vert_r[ST_OUT][3],
                       vert_r[ST_OUT][2], vert_r[ST_OUT][1], vert_r[ST_OUT][0]};

  a_par_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0)
    else $error("parallel item carries nonzero results");

  a_area_sides: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[OUT_W-1 -: AREA_W] != '0) |->
      (side_r[ST_OUT][0] != '0) && (side_r[ST_OUT][1] != '0) && (side_r[ST_OUT][2] != '0))
    else $error("nonzero area with a zero side");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[ST_OUT-1] && en |=> out_tvalid)
    else $error("item lost in last stage");

endmodule
`default_nettype wire
